// File: sv/memory_pattern_self_test_defines.svh
// Assertion macros used by the memory pattern self-test sequencer core.
`ifndef MEMORY_PATTERN_SELF_TEST_DEFINES_SVH
`define MEMORY_PATTERN_SELF_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define MPST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("mpst assertion failed");
// Condition must never be seen outside reset.
`define MPST_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("mpst forbidden condition seen");
`else
`define MPST_ASSERT(label, clk, rst_n, prop)
`define MPST_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: sv/mpst_pkg.sv
// Types, constants and codes shared by the memory pattern self-test modules.
package mpst_pkg;

    localparam int MAX_ADDR_BITS_DEF = 20;
    localparam int LOG2_W            = 5;
    localparam int DATA_W            = 32;
    localparam int MEM_ADDR_W        = 20;
    localparam int ERR_W             = 22;

    localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(14);
    localparam logic [LOG2_W-1:0] LOG2_MIN   = LOG2_W'(1);
    localparam logic [DATA_W-1:0] PAT_XOR    = 32'hA5A5_A5A5;
    localparam logic [DATA_W-1:0] MARKER     = 32'hDEAD_0000;
    localparam logic [ERR_W-1:0]  ERR_MAX    = {ERR_W{1'b1}};

    // Input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_WR_PAT  = 8'b0000_0010,
        PH_RD_PAT  = 8'b0000_0100,
        PH_WR_INV  = 8'b0000_1000,
        PH_RD_INV  = 8'b0001_0000,
        PH_WR_MARK = 8'b0010_0000,
        PH_RD_MARK = 8'b0100_0000,
        PH_FINAL   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] read_data;
    } t_item;

    typedef struct packed {
        logic                  mem_valid;
        logic                  mem_write;
        logic [MEM_ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0]     mem_wdata;
        logic                  test_done;
        logic                  test_passed;
        logic [ERR_W-1:0]      error_count;
    } t_result;

endpackage

// File: sv/mpst_in_stage.sv
// Input register stage: captures one step/start transaction per cycle while empty or while its held item is taken.
module mpst_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mpst_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output mpst_pkg::t_item o_item
);
    import mpst_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/mpst_core.sv
// Sequencer core: phase state, command generation and read-back compare.
`include "memory_pattern_self_test_defines.svh"

module mpst_core #(
    parameter int MAX_ADDR_BITS = mpst_pkg::MAX_ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  mpst_pkg::t_item               i_item,
    input  logic [mpst_pkg::LOG2_W-1:0]   i_word_count_log2,
    output mpst_pkg::t_result             o_res
);
    import mpst_pkg::*;

    localparam int AW = MAX_ADDR_BITS;
    localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(MAX_ADDR_BITS);

    t_phase              r_phase,   n_phase;
    logic [AW-1:0]       r_idx,     n_idx;
    logic                r_pend,    n_pend;
    logic [DATA_W-1:0]   r_exp,     n_exp;
    logic [ERR_W-1:0]    r_err,     n_err;
    logic                r_fin,     n_fin;

    logic [LOG2_W-1:0]   lg;
    logic [AW-1:0]       last_idx;
    logic [DATA_W-1:0]   pat;
    logic [DATA_W-1:0]   offs;
    logic [DATA_W-1:0]   addr32;
    logic                mark_end;
    t_phase              phase_after;

    // effective size, clamped into the legal range
    always_comb begin
        if (i_word_count_log2 < LOG2_MIN) begin
            lg = LOG2_MIN;
        end else if (i_word_count_log2 > LOG2_MAX) begin
            lg = LOG2_MAX;
        end else begin
            lg = i_word_count_log2;
        end
    end

    assign last_idx = ~({AW{1'b1}} << lg);
    assign mark_end = r_idx >= AW'(lg);
    assign offs     = mark_end ? '0 : (DATA_W'(1) << r_idx);

    always_comb begin
        pat = DATA_W'(r_idx) ^ PAT_XOR;
        if (r_phase == PH_WR_INV || r_phase == PH_RD_INV) begin
            pat = ~pat;
        end
    end

    always_comb begin
        case (r_phase)
            PH_WR_PAT:  phase_after = PH_RD_PAT;
            PH_RD_PAT:  phase_after = PH_WR_INV;
            PH_WR_INV:  phase_after = PH_RD_INV;
            PH_RD_INV:  phase_after = PH_WR_MARK;
            PH_WR_MARK: phase_after = PH_RD_MARK;
            PH_RD_MARK: phase_after = PH_FINAL;
            default:    phase_after = PH_IDLE;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_exp   = r_exp;
        n_err   = r_err;
        n_fin   = r_fin;
        addr32  = '0;
        o_res   = '0;

        if (i_item.kind == KIND_START) begin
            n_phase = PH_WR_PAT;
            n_idx   = '0;
            n_pend  = 1'b0;
            n_exp   = '0;
            n_err   = '0;
            n_fin   = 1'b0;
        end else begin
            if (r_pend) begin
                if (i_item.read_data != r_exp && r_err != ERR_MAX) begin
                    n_err = r_err + ERR_W'(1);
                end
                n_pend = 1'b0;
            end
            case (r_phase)
                PH_WR_PAT, PH_RD_PAT, PH_WR_INV, PH_RD_INV: begin
                    o_res.mem_valid = 1'b1;
                    addr32          = DATA_W'(r_idx);
                    if (r_phase == PH_WR_PAT || r_phase == PH_WR_INV) begin
                        o_res.mem_write = 1'b1;
                        o_res.mem_wdata = pat;
                    end else begin
                        n_exp  = pat;
                        n_pend = 1'b1;
                    end
                    if (r_idx >= last_idx) begin
                        n_phase = phase_after;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                PH_WR_MARK, PH_RD_MARK: begin
                    o_res.mem_valid = 1'b1;
                    addr32          = offs;
                    if (r_phase == PH_WR_MARK) begin
                        o_res.mem_write = 1'b1;
                        o_res.mem_wdata = MARKER | offs;
                    end else begin
                        n_exp  = MARKER | offs;
                        n_pend = 1'b1;
                    end
                    if (mark_end) begin
                        n_phase = phase_after;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                PH_FINAL: begin
                    n_fin   = 1'b1;
                    n_phase = PH_IDLE;
                    n_idx   = '0;
                end
                default: begin
                end
            endcase
        end

        o_res.mem_addr    = addr32[MEM_ADDR_W-1:0];
        o_res.test_done   = n_fin;
        o_res.test_passed = n_fin && (n_err == '0);
        o_res.error_count = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_exp   <= '0;
            r_err   <= '0;
            r_fin   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_exp   <= n_exp;
            r_err   <= n_err;
            r_fin   <= n_fin;
        end
    end

    // commands only come out of the six test phases
    `MPST_ASSERT_NEVER(a_cmd_outside_test, i_clk, i_rst_n,
        i_fire && o_res.mem_valid && (r_phase == PH_IDLE || r_phase == PH_FINAL))
    // error count only moves up between starts
    `MPST_ASSERT(a_err_monotonic, i_clk, i_rst_n,
        (i_fire && i_item.kind == KIND_STEP) |=> (r_err >= $past(r_err)))
    // done is only held while the sequencer is parked
    `MPST_ASSERT(a_done_idle, i_clk, i_rst_n, r_fin |-> (r_phase == PH_IDLE))

endmodule

// File: sv/mpst_out_stage.sv
// Result register stage: holds one result transaction until it is taken.
module mpst_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mpst_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output mpst_pkg::t_result o_res
);
    import mpst_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: sv/memory_pattern_self_test.sv
// Memory pattern self-test sequencer, top level.
//
// Runs a pattern test on an external word memory, at most one memory command per
// step transaction. A start transaction (kind 0) clears the error count and
// the done flag and begins the test; each step transaction (kind 1) returns
// one result carrying at most one command (read or write) plus the test
// status. The read data answering a read command is supplied with the next
// step transaction. Phases: write index^0xA5A5A5A5 to all words, read back,
// write the complement, read back, write 0xDEAD0000|offset at every
// power-of-two offset and then word 0, read those back; one more step does
// the last compare and raises done. Mismatches saturate at 2^22-1.
// Throughput is one transaction per cycle sustained while the result channel
// is ready; an accepted input passes through the input register, then the
// sequencer logic into the result register. The size register
// (log2 of the word count, reset 14, clamped to 1..MAX_ADDR_BITS) must only
// be written while no transaction is in flight; its port is always ready.
module memory_pattern_self_test #(
    parameter int MAX_ADDR_BITS = mpst_pkg::MAX_ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpst_pkg::LOG2_W-1:0]       i_cfg_data,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic [mpst_pkg::DATA_W-1:0]       i_read_data,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_mem_valid,
    output logic                              o_mem_write,
    output logic [mpst_pkg::MEM_ADDR_W-1:0]   o_mem_addr,
    output logic [mpst_pkg::DATA_W-1:0]       o_mem_wdata,
    output logic                              o_test_done,
    output logic                              o_test_passed,
    output logic [mpst_pkg::ERR_W-1:0]        o_error_count
);
    import mpst_pkg::*;

    logic [LOG2_W-1:0] r_word_count_log2;

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    out_space;
    logic    fire;
    t_result core_res;
    t_result out_res;

    // size register, written whenever its channel presents data
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count_log2 <= LOG2_RESET;
        end else if (i_cfg_valid) begin
            r_word_count_log2 <= i_cfg_data;
        end
    end

    assign in_item.kind      = i_kind;
    assign in_item.read_data = i_read_data;

    // the registered item moves into the sequencer when the result slot frees
    assign fire = st_valid && out_space;

    mpst_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .i_take  (fire),
        .o_item  (st_item)
    );

    mpst_core #(
        .MAX_ADDR_BITS (MAX_ADDR_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_item            (st_item),
        .i_word_count_log2 (r_word_count_log2),
        .o_res             (core_res)
    );

    mpst_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (st_valid),
        .i_res   (core_res),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_mem_valid   = out_res.mem_valid;
    assign o_mem_write   = out_res.mem_write;
    assign o_mem_addr    = out_res.mem_addr;
    assign o_mem_wdata   = out_res.mem_wdata;
    assign o_test_done   = out_res.test_done;
    assign o_test_passed = out_res.test_passed;
    assign o_error_count = out_res.error_count;

endmodule
